[sv/sll_pkg.sv]
`timescale 1ns / 1ps
// Shared types, token codes and keyword tables for the lexer.
// Used by self_language_lexer; depends on nothing.
package sll_pkg;

   localparam int MAX_LEXEME_DEF   = 128;
   localparam int OFFSET_WIDTH_DEF = 32;
   localparam int NUM_KW           = 15;
   localparam int KW_CHARS         = 18;

   // one input beat
   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_source;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [5:0]  token_kind;
      logic [31:0] lexeme_start;
      logic [7:0]  lexeme_length;
      logic        length_saturated;
      logic        last_of_run;
   } rsp_type;

   // token kinds
   localparam logic [5:0] KIND_ERROR    = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd16;
   localparam logic [5:0] KIND_SMALL_KW = 6'd17;
   localparam logic [5:0] KIND_CAP_KW   = 6'd18;
   localparam logic [5:0] KIND_ARG      = 6'd19;
   localparam logic [5:0] KIND_STRING   = 6'd20;
   localparam logic [5:0] KIND_INT      = 6'd22;
   localparam logic [5:0] KIND_REAL     = 6'd23;

   // keyword texts, right aligned, first char in the highest used byte
   localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
      "self", "resend", "_Quit", "_RunScript", "_RemoveAllSlots", "_Clone",
      "_Mirror", "_Print", "_AddSlots:", "_Define:", "_AddSlotsIfAbsent:",
      "_RemoveSlot:", "_Eq:", "_IntAdd:", "_IntDiv:"
   };
   localparam logic [4:0] KW_LEN [NUM_KW] = '{
      5'd4, 5'd6, 5'd5, 5'd10, 5'd15, 5'd6, 5'd7, 5'd6, 5'd10, 5'd8, 5'd18,
      5'd12, 5'd4, 5'd8, 5'd8
   };
   localparam logic [5:0] KW_KIND [NUM_KW] = '{
      6'd1, 6'd2, 6'd4, 6'd5, 6'd9, 6'd11, 6'd14, 6'd15, 6'd3, 6'd6, 6'd7,
      6'd8, 6'd10, 6'd12, 6'd13
   };
   // keywords that end in a colon
   localparam logic [NUM_KW-1:0] KW_COLON = 15'h7F00;

   function automatic logic is_lower(input logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return is_lower(c) || is_upper(c);
   endfunction

   function automatic logic ident_cont(input logic [7:0] c);
      return c == "_" || is_alpha(c) || is_digit(c);
   endfunction

   function automatic logic is_e(input logic [7:0] c);
      return c == "e" || c == "E";
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return c == "+" || c == "-";
   endfunction

   function automatic logic real_ok(input logic [7:0] p);
      return !(p == "." || is_e(p) || is_sign(p));
   endfunction

   // keyword k has byte c at position p
   function automatic logic kw_char_hit(input int k, input logic [7:0] p,
                                        input logic [7:0] c);
      int idx;
      idx = 0;
      if (p >= 8'(KW_LEN[k])) begin
         return 1'b0;
      end
      idx = (int'(KW_LEN[k]) - 1 - int'(p)) * 8;
      return KW_TEXT[k][idx +: 8] == c;
   endfunction

   // punctuation kind, or the error kind for any other byte
   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "!":     k = 6'd24;
         "@":     k = 6'd25;
         "#":     k = 6'd26;
         "$":     k = 6'd27;
         "%":     k = 6'd28;
         "^":     k = 6'd29;
         "&":     k = 6'd30;
         "*":     k = 6'd31;
         "-":     k = 6'd32;
         "+":     k = 6'd33;
         "=":     k = 6'd34;
         "~":     k = 6'd35;
         "/":     k = 6'd36;
         "?":     k = 6'd37;
         "<":     k = 6'd38;
         ">":     k = 6'd39;
         ",":     k = 6'd40;
         ";":     k = 6'd41;
         "|":     k = 6'd42;
         8'h5C:   k = 6'd43;
         ".":     k = 6'd44;
         "(":     k = 6'd45;
         ")":     k = 6'd46;
         "[":     k = 6'd47;
         "]":     k = 6'd48;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

[sv/self_language_lexer.sv]
`timescale 1ns / 1ps
// Byte-at-a-time lexer: lexeme tracking and a four-entry result queue.
// Depends on sll_pkg.
//
//   channel | ports                          | payload
//   input   | req_valid, req_stall, req_data | sll_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data | sll_pkg::rsp_type
//
// One source byte is taken per cycle unless req_stall is high; its tokens
// (zero to two) enter the result queue at the same edge and leave one per
// cycle from the queue head unless rsp_stall is high. The queue drain sets
// the rate: req_stall rises while three or more beats wait. Synchronous
// reset empties the queue and returns the lexer to idle. A stalled result
// beat holds in the queue; input keeps flowing until three beats wait.
module self_language_lexer #(
   parameter int MAX_LEXEME   = sll_pkg::MAX_LEXEME_DEF,
   parameter int OFFSET_WIDTH = sll_pkg::OFFSET_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sll_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sll_pkg::rsp_type rsp_data
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_LEXEME);

   typedef enum logic [7:0] {
      MD_IDLE    = 8'b0000_0001,
      MD_IDENT   = 8'b0000_0010,
      MD_CAP     = 8'b0000_0100,
      MD_ARG     = 8'b0000_1000,
      MD_STRING  = 8'b0001_0000,
      MD_COMMENT = 8'b0010_0000,
      MD_INT     = 8'b0100_0000,
      MD_REAL    = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      mode_type                     mode;
      logic [7:0]                   plen;
      logic [OFFSET_WIDTH-1:0]      pstart;
      logic                         radix;
      logic [7:0]                   prev;
      logic [sll_pkg::NUM_KW-1:0]   kw;
      logic                         ovf;
   } lex_state_type;

   lex_state_type           lex_ff, lex_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;

   sll_pkg::rsp_type fifo_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   logic             req_fire, rsp_fire;
   logic [1:0]       push_n;
   sll_pkg::rsp_type slot0, slot1;

   // extend the pending lexeme by one byte
   function automatic lex_state_type append_byte(input lex_state_type s,
                                                 input logic [7:0] c);
      lex_state_type r;
      r = s;
      if (s.mode == MD_IDENT) begin
         for (int k = 0; k < sll_pkg::NUM_KW; k++) begin
            if (!sll_pkg::kw_char_hit(k, s.plen, c)) r.kw[k] = 1'b0;
         end
      end
      if (s.ovf || s.plen >= MAX_LEN) begin
         r.ovf = 1'b1;
         r.kw  = '0;
      end else begin
         r.plen = s.plen + 8'd1;
      end
      r.prev = c;
      return r;
   endfunction

   function automatic lex_state_type begin_lexeme(input lex_state_type s,
                                                  input mode_type m,
                                                  input logic [OFFSET_WIDTH-1:0] p,
                                                  input logic [7:0] c);
      lex_state_type r;
      r        = s;
      r.mode   = m;
      r.pstart = p;
      r.plen   = 8'd0;
      r.ovf    = 1'b0;
      r.kw     = '1;
      return append_byte(r, c);
   endfunction

   function automatic logic [5:0] word_match(input lex_state_type s);
      logic [5:0] w;
      w = sll_pkg::KIND_ERROR;
      for (int k = sll_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (s.kw[k] && 8'(sll_pkg::KW_LEN[k]) == s.plen && !sll_pkg::KW_COLON[k])
            w = sll_pkg::KW_KIND[k];
      end
      return w;
   endfunction

   function automatic logic [5:0] colon_match(input lex_state_type s);
      logic [5:0] w;
      w = sll_pkg::KIND_ERROR;
      for (int k = sll_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (s.kw[k] && 9'(sll_pkg::KW_LEN[k]) == 9'(s.plen) + 9'd1 &&
             sll_pkg::KW_COLON[k])
            w = sll_pkg::KW_KIND[k];
      end
      return w;
   endfunction

   function automatic sll_pkg::rsp_type pend_tok(input logic [5:0] kind,
                                                 input lex_state_type s);
      sll_pkg::rsp_type t;
      t.token_kind       = kind;
      t.lexeme_start     = 32'(s.pstart);
      t.lexeme_length    = s.plen;
      t.length_saturated = s.ovf;
      t.last_of_run      = 1'b0;
      return t;
   endfunction

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff >= 3'd3;
   assign rsp_valid = count_ff != 3'd0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // lex one byte: continue, restart, flush
   always_comb begin
      lex_state_type    s;
      logic [7:0]       c;
      logic             taken, e1v, e2v, e3v;
      sll_pkg::rsp_type e1, e2, e3;
      logic [5:0]       w;
      logic [1:0]       n;
      s     = lex_ff;
      c     = req_data.source_byte;
      taken = 1'b0;
      e1v   = 1'b0;
      e2v   = 1'b0;
      e3v   = 1'b0;
      e1    = '0;
      e2    = '0;
      e3    = '0;
      w     = sll_pkg::KIND_ERROR;

      // continue the pending lexeme
      case (s.mode)
         MD_IDLE: begin
         end
         MD_IDENT: begin
            if (sll_pkg::ident_cont(c)) begin
               s = append_byte(s, c);
               taken = 1'b1;
            end else begin
               w = word_match(s);
               if (w != sll_pkg::KIND_ERROR) begin
                  e1v = 1'b1; e1 = pend_tok(w, s);
               end else if (c == ":") begin
                  w = colon_match(s);
                  s = append_byte(s, c);
                  e1v = 1'b1;
                  e1 = pend_tok((w != sll_pkg::KIND_ERROR) ? w : sll_pkg::KIND_SMALL_KW, s);
                  taken = 1'b1;
               end else begin
                  e1v = 1'b1; e1 = pend_tok(sll_pkg::KIND_IDENT, s);
               end
               s.mode = MD_IDLE;
            end
         end
         MD_CAP: begin
            s = append_byte(s, c);
            taken = 1'b1;
            if (!sll_pkg::ident_cont(c)) begin
               e1v = 1'b1;
               e1 = pend_tok((c == ":") ? sll_pkg::KIND_CAP_KW : sll_pkg::KIND_ERROR, s);
               s.mode = MD_IDLE;
            end
         end
         MD_ARG: begin
            if ((s.plen == 8'd1) ? (c == "_" || sll_pkg::is_lower(c))
                                 : sll_pkg::ident_cont(c)) begin
               s = append_byte(s, c);
               taken = 1'b1;
            end else begin
               e1v = 1'b1; e1 = pend_tok(sll_pkg::KIND_ARG, s);
               s.mode = MD_IDLE;
            end
         end
         MD_STRING: begin
            s = append_byte(s, c);
            taken = 1'b1;
            if (c == "'") begin
               e1v = 1'b1; e1 = pend_tok(sll_pkg::KIND_STRING, s);
               s.mode = MD_IDLE;
            end
         end
         MD_COMMENT: begin
            s = append_byte(s, c);
            taken = 1'b1;
            if (c == "\"") s.mode = MD_IDLE;
         end
         MD_INT: begin
            if (!s.radix && (c == "." || sll_pkg::is_e(c))) begin
               s = append_byte(s, c);
               s.mode = MD_REAL;
               taken = 1'b1;
            end else if (c == "r" || c == "R") begin
               s = append_byte(s, c);
               s.radix = 1'b1;
               taken = 1'b1;
            end else if (sll_pkg::is_digit(c) || (s.radix && sll_pkg::is_alpha(c))) begin
               s = append_byte(s, c);
               taken = 1'b1;
            end else begin
               s.radix = 1'b0;
               e1v = 1'b1; e1 = pend_tok(sll_pkg::KIND_INT, s);
               s.mode = MD_IDLE;
            end
         end
         MD_REAL: begin
            if (sll_pkg::is_digit(c) ||
                (sll_pkg::is_e(c) && sll_pkg::is_digit(s.prev)) ||
                (sll_pkg::is_sign(c) && sll_pkg::is_e(s.prev))) begin
               s = append_byte(s, c);
               taken = 1'b1;
            end else begin
               s.radix = 1'b0;
               e1v = 1'b1;
               e1 = pend_tok((!sll_pkg::is_e(c) && !sll_pkg::is_sign(c) &&
                              sll_pkg::real_ok(s.prev)) ? sll_pkg::KIND_REAL
                                                        : sll_pkg::KIND_ERROR, s);
               s.mode = MD_IDLE;
            end
         end
         default: s.mode = MD_IDLE;
      endcase

      // start a new lexeme, skip white space, or emit a one-byte token
      if (!taken) begin
         if (c == "_" || sll_pkg::is_lower(c)) begin
            s = begin_lexeme(s, MD_IDENT, pos_ff, c);
         end else if (sll_pkg::is_upper(c)) begin
            s = begin_lexeme(s, MD_CAP, pos_ff, c);
         end else if (c == ":") begin
            s = begin_lexeme(s, MD_ARG, pos_ff, c);
         end else if (c == "'") begin
            s = begin_lexeme(s, MD_STRING, pos_ff, c);
         end else if (c == "\"") begin
            s = begin_lexeme(s, MD_COMMENT, pos_ff, c);
         end else if (c == " " || c == 8'h0A || c == 8'h09) begin
            s = s;
         end else if (sll_pkg::is_digit(c)) begin
            s.radix = 1'b0;
            s = begin_lexeme(s, MD_INT, pos_ff, c);
         end else begin
            e2v = 1'b1;
            e2.token_kind       = sll_pkg::punct_kind(c);
            e2.lexeme_start     = 32'(pos_ff);
            e2.lexeme_length    = 8'd1;
            e2.length_saturated = 1'b0;
            e2.last_of_run      = 1'b0;
         end
      end

      // flush at the end of the source
      pos_in = pos_ff + 1'b1;
      if (req_data.end_of_source) begin
         case (s.mode)
            MD_IDENT: begin
               w = word_match(s);
               e3v = 1'b1;
               e3 = pend_tok((w != sll_pkg::KIND_ERROR) ? w : sll_pkg::KIND_IDENT, s);
            end
            MD_CAP:    begin e3v = 1'b1; e3 = pend_tok(sll_pkg::KIND_ERROR, s); end
            MD_ARG:    begin e3v = 1'b1; e3 = pend_tok(sll_pkg::KIND_ARG, s); end
            MD_STRING: begin e3v = 1'b1; e3 = pend_tok(sll_pkg::KIND_ERROR, s); end
            MD_INT:    begin e3v = 1'b1; e3 = pend_tok(sll_pkg::KIND_INT, s); end
            MD_REAL: begin
               e3v = 1'b1;
               e3 = pend_tok(sll_pkg::real_ok(s.prev) ? sll_pkg::KIND_REAL
                                                      : sll_pkg::KIND_ERROR, s);
            end
            default: begin
            end
         endcase
         s.mode  = MD_IDLE;
         s.radix = 1'b0;
         pos_in  = '0;
      end

      // pack the tokens of this byte into two slots, in order
      n     = 2'(e1v) + 2'(e2v) + 2'(e3v);
      slot0 = e1v ? e1 : (e2v ? e2 : e3);
      slot1 = (e1v && e2v) ? e2 : e3;
      slot0.last_of_run = (n == 2'd1);
      slot1.last_of_run = 1'b1;

      lex_in = s;
      push_n = req_fire ? n : 2'd0;
      if (!req_fire) begin
         lex_in = lex_ff;
         pos_in = pos_ff;
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + 2'(rsp_fire);
      count_in  = count_ff + 3'(push_n) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff.mode   <= MD_IDLE;
         lex_ff.plen   <= '0;
         lex_ff.pstart <= '0;
         lex_ff.radix  <= 1'b0;
         lex_ff.prev   <= '0;
         lex_ff.kw     <= '1;
         lex_ff.ovf    <= 1'b0;
         pos_ff        <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         lex_ff    <= lex_in;
         pos_ff    <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write result beats into the queue
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_ff[wr_ptr_ff] <= slot0;
      if (push_n == 2'd2) fifo_ff[wr_ptr_ff + 2'd1] <= slot1;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("result queue overfilled");

   a_eos_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.end_of_source) |=> (lex_ff.mode == MD_IDLE && pos_ff == '0))
      else $error("lexer not idle after end of source");

   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      lex_ff.ovf |-> lex_ff.plen == MAX_LEN) else $error("saturation flag without full length");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff[1:0] == wr_ptr_ff - rd_ptr_ff) else $error("queue pointers out of step");

endmodule
